// ===== rtl/integer_to_ascii_radix_core_defines.svh =====
// Assertion helpers for the integer to ASCII core.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// Plain property check.
`define ITAR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define ITAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itar_pkg.sv =====
// ----------------------------------------------------------------------------
// itar_pkg
// Widths, radix codes, sequencer states, ASCII constants and the digit encoder of the
// integer to ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package itar_pkg;

	localparam int WORD_BITS  = 16;
	localparam int MAX_DIGITS = WORD_BITS;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

	// x / 10 == (x * RECIP) >> RECIP_SHIFT for every x below 2**WORD_BITS;
	// the rounding error stays under 1/16.
	localparam int RECIP_SHIFT = WORD_BITS + 4;
	localparam logic [WORD_BITS:0] RECIP =
		(WORD_BITS + 1)'((((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10));

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h37; // 'A' - 10
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [3:0] DEC_RADIX  = 4'd10;

	typedef enum logic [1:0] {
		MODE_BIN = 2'd0,
		MODE_OCT = 2'd1,
		MODE_DEC = 2'd2,
		MODE_HEX = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] base;
		base = (d < DEC_RADIX) ? CHAR_ZERO : CHAR_ALPHA;
		return base + {4'b0000, d};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_radix_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core: one digit a cycle through a shared divide step,
// then one character a cycle from the digit buffer while txt_stall allows;
// a negative decimal value gets a leading '-'. num_stall stays high until the
// item is emitted. Async active-low reset clears the sequencer and valid.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  num_valid,
	output logic                                 num_stall,
	input  wire signed [itar_pkg::WORD_BITS-1:0] value,
	input  wire        [1:0]                     mode,
	output logic                                 txt_valid,
	input  wire                                  txt_stall,
	output logic       [7:0]                     character,
	output logic                                 last
);
	import itar_pkg::*;

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] mag_q, mag_next, raw;
	logic [2*WORD_BITS:0] prod;
	logic [WORD_BITS-1:0] dec_quo;
	logic [3:0]           dec_rem, digit;
	mode_t                mode_q;
	logic                 sign_q, neg;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic [3:0]           buf_q [MAX_DIGITS];

	logic       accept, load, last_d, txt_valid_q, last_q;
	logic [7:0] char_d, char_q;

	assign accept = num_valid && !num_stall;
	assign raw    = value;
	assign neg    = raw[WORD_BITS-1] && (mode_t'(mode) == MODE_DEC);

	// Shared divide step: constant reciprocal for decimal, shifts otherwise.
	assign prod    = mag_q * RECIP;
	assign dec_quo = WORD_BITS'(prod[2*WORD_BITS:RECIP_SHIFT]);
	// True remainder is below ten, so four bits of the difference suffice.
	assign dec_rem = mag_q[3:0] - {dec_quo[0], 3'b000} - {dec_quo[2:0], 1'b0};

	always_comb begin
		case (mode_q)
			MODE_BIN: begin
				digit    = {3'b000, mag_q[0]};
				mag_next = mag_q >> 1;
			end
			MODE_OCT: begin
				digit    = {1'b0, mag_q[2:0]};
				mag_next = mag_q >> 3;
			end
			MODE_DEC: begin
				digit    = dec_rem;
				mag_next = dec_quo;
			end
			default: begin
				digit    = mag_q[3:0];
				mag_next = mag_q >> 4;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CONV;
			ST_CONV: if (mag_next == '0) state_d = ST_EMIT;
			ST_EMIT: if (load && !sign_q && idx_q == '0) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		num_stall = 1'b1;
		load      = 1'b0;
		char_d    = CHAR_MINUS;
		last_d    = 1'b0;
		unique case (state_q)
			ST_IDLE: num_stall = 1'b0;
			ST_CONV: ;
			ST_EMIT: begin
				load = !txt_valid_q || !txt_stall;
				if (!sign_q) begin
					char_d = digit_char(buf_q[idx_q]);
					last_d = (idx_q == '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sign_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			txt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sign_q <= neg;
				cnt_q  <= '0;
			end
			if (state_q == ST_CONV) begin
				cnt_q <= cnt_q + 1'b1;
				idx_q <= cnt_q[IDX_W-1:0];
			end
			if (load) begin
				if (sign_q) sign_q <= 1'b0;
				else        idx_q  <= idx_q - 1'b1;
			end
			if (load)           txt_valid_q <= 1'b1;
			else if (!txt_stall) txt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= neg ? (~raw + 1'b1) : raw;
			mode_q <= mode_t'(mode);
		end else if (state_q == ST_CONV) begin
			mag_q <= mag_next;
		end
		if (state_q == ST_CONV) buf_q[cnt_q[IDX_W-1:0]] <= digit;
		if (load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign txt_valid = txt_valid_q;
	assign character = char_q;
	assign last      = last_q;

`include "integer_to_ascii_radix_core_defines.svh"

	`ITAR_ASSERT(a_cnt_bound, (state_q != ST_CONV) || (cnt_q < CNT_W'(MAX_DIGITS)), "digit overflow")
	`ITAR_ASSERT(a_dec_rem, (state_q != ST_CONV) || (mode_q != MODE_DEC) || (dec_rem < DEC_RADIX), "bad remainder")
	`ITAR_ASSERT_NEXT(a_accept_conv, accept, state_q == ST_CONV, "accept did not start conversion")
	`ITAR_ASSERT_NEXT(a_last_idle, load && last_d, state_q == ST_IDLE, "sequencer busy after last item")

endmodule

`default_nettype wire
